// ----- rtl/etg_pkg.sv -----
// Shared constants, codes and the quarter-sine table of the eased tween generator.
package etg_pkg;

    // Number formats
    localparam int FRACTION_BITS      = 16;
    localparam int TIME_BITS          = 24;
    localparam int VALUE_BITS         = 32;
    localparam int SINE_TABLE_ENTRIES = 256;
    localparam int SINE_IDX_BITS      = $clog2(SINE_TABLE_ENTRIES);
    localparam int SINE_ADDR_BITS     = SINE_IDX_BITS + 1;
    localparam int SINE_W             = FRACTION_BITS + 1;

    // Stream beat layout
    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 72;

    // Request kinds
    localparam logic [1:0] REQ_SNAP    = 2'd0;
    localparam logic [1:0] REQ_MOVE    = 2'd1;
    localparam logic [1:0] REQ_ADVANCE = 2'd2;

    // Curve kinds
    localparam logic [1:0] CURVE_LINEAR   = 2'd0;
    localparam logic [1:0] CURVE_EASE_OUT = 2'd1;
    localparam logic [1:0] CURVE_IN_OUT   = 2'd2;

    localparam logic [SINE_W-1:0] ONE_FRAC  = SINE_W'(1) << FRACTION_BITS;
    localparam logic [SINE_W-1:0] HALF_FRAC = SINE_W'(1) << (FRACTION_BITS - 1);

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef logic [SINE_W-1:0] sine_tab_t [0:SINE_TABLE_ENTRIES];

    // Build sin(i/N * pi/2) in Q1.FRACTION_BITS with a Q2.30 Taylor series
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] e;
        longint      sum;
        int          i;
        int          k;
        for (i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
            x    = (PI_Q30 * 64'(i) + 64'(SINE_TABLE_ENTRIES)) / 64'(2 * SINE_TABLE_ENTRIES);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (k = 1; k <= 9; k++) begin
                term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if ((k % 2) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            e = (64'(sum) + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
            if (e > 64'(ONE_FRAC))
                e = 64'(ONE_FRAC);
            tab[i] = e[SINE_W-1:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ----- rtl/eased_tween_generator_core.sv -----
// Eased tween generator: one tween, serial divider and shared multiplier under a sequencer.
// A settled item runs S_PRE, S_APPLY, S_POST and S_FIN; a still-moving one also runs the
// 16-step progress divider and, for eased curves, the table and multiplier states, and a move
// that retargets a running tween computes the value twice (once before the move is applied).
// A new beat is taken in the cycle after the result is handed to the output register, and not
// before, so items are handled one at a time.
// rst_n clears the tween to zero, linear and settled, and empties the output register.
module eased_tween_generator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // new_value[31:0], move_duration[55:32], ease_kind[57:56], tick_time[81:58], zero pad
    input  logic [etg_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [etg_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // current_value[31:0], target_value[63:32], moving[64], tick_taken[65], zero pad
    output logic [etg_pkg::OUT_DATA_W-1:0] m_tdata
);
    import etg_pkg::*;

    localparam int VB        = VALUE_BITS;
    localparam int FB        = FRACTION_BITS;
    localparam int TB        = TIME_BITS;
    localparam int MUL_A_W   = VB + 2;
    localparam int MUL_B_W   = FB + 2;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int DIV_CNT_W = $clog2(FB);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PRE    = 4'd1;
    localparam logic [3:0] S_APPLY  = 4'd2;
    localparam logic [3:0] S_POST   = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_LOOKA  = 4'd5;
    localparam logic [3:0] S_LOOKB  = 4'd6;
    localparam logic [3:0] S_INTERP = 4'd7;
    localparam logic [3:0] S_SQ     = 4'd8;
    localparam logic [3:0] S_SPAN   = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    // Control and tween state
    logic [3:0]            state_reg, state_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic signed [VB-1:0]  start_value_reg, start_value_next;
    logic signed [VB-1:0]  end_value_reg, end_value_next;
    logic [TB-1:0]         elapsed_time_reg, elapsed_time_next;
    logic [TB-1:0]         total_time_reg, total_time_next;
    logic [1:0]            curve_kind_reg, curve_kind_next;

    // Payload and datapath registers
    logic [1:0]                  req_reg, req_next;
    logic signed [VB-1:0]        nv_reg, nv_next;
    logic [TB-1:0]               dur_reg, dur_next;
    logic [1:0]                  kind_in_reg, kind_in_next;
    logic [TB-1:0]               dt_reg, dt_next;
    logic signed [VB-1:0]        cur_reg, cur_next;
    logic                        taken_reg, taken_next;
    logic                        ret_pre_reg, ret_pre_next;
    logic [TB-1:0]               rem_reg, rem_next;
    logic [FB-1:0]               q_reg, q_next;
    logic [DIV_CNT_W-1:0]        div_cnt_reg, div_cnt_next;
    logic [SINE_W-1:0]           a_reg, a_next;
    logic signed [MUL_A_W-1:0]   mul_a_reg, mul_a_next;
    logic signed [MUL_B_W-1:0]   mul_b_reg, mul_b_next;
    logic [OUT_DATA_W-1:0]       out_data_reg, out_data_next;

    // Datapath wires
    logic                        moving_now;
    logic signed [VB:0]          span;
    logic signed [MUL_P_W-1:0]   mul_p;
    logic signed [MUL_P_W-1:0]   mul_rnd;
    logic signed [MUL_P_W-1:0]   mul_shift;
    logic [TB:0]                 trial;
    logic                        trial_ge;
    logic [TB:0]                 tick_sum;
    logic [SINE_IDX_BITS-1:0]    tab_idx;
    logic [SINE_ADDR_BITS-1:0]   tab_addr;
    logic [SINE_W-1:0]           tab_rd;
    logic [SINE_W-1:0]           tab_diff;
    logic [FB-1:0]               tab_frac;
    logic [SINE_W-1:0]           rnd_frac;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    // Shared multiplier with rounding to the fraction point
    assign mul_p     = mul_a_reg * mul_b_reg;
    assign mul_rnd   = mul_p + $signed(MUL_P_W'(HALF_FRAC));
    assign mul_shift = mul_rnd >>> FB;
    assign rnd_frac  = mul_shift[SINE_W-1:0];

    // Tween status and span
    assign moving_now = (total_time_reg != '0) && (elapsed_time_reg < total_time_reg);
    assign span       = {end_value_reg[VB-1], end_value_reg}
                        - {start_value_reg[VB-1], start_value_reg};
    assign tick_sum   = {1'b0, elapsed_time_reg} + {1'b0, dt_reg};

    // Restoring divider step
    assign trial    = {rem_reg, 1'b0};
    assign trial_ge = (trial >= {1'b0, total_time_reg});

    // Quarter-sine table, one read per cycle
    assign tab_idx  = q_reg[FB-1 -: SINE_IDX_BITS];
    assign tab_frac = {q_reg[FB-SINE_IDX_BITS-1:0], {SINE_IDX_BITS{1'b0}}};
    assign tab_addr = (state_reg == S_LOOKB) ? ({1'b0, tab_idx} + SINE_ADDR_BITS'(1))
                                             : {1'b0, tab_idx};
    assign tab_rd   = SINE_TAB[tab_addr];
    assign tab_diff = (tab_rd < a_reg) ? '0 : (tab_rd - a_reg);

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        m_tvalid_next     = m_tvalid_reg;
        start_value_next  = start_value_reg;
        end_value_next    = end_value_reg;
        elapsed_time_next = elapsed_time_reg;
        total_time_next   = total_time_reg;
        curve_kind_next   = curve_kind_reg;
        req_next          = req_reg;
        nv_next           = nv_reg;
        dur_next          = dur_reg;
        kind_in_next      = kind_in_reg;
        dt_next           = dt_reg;
        cur_next          = cur_reg;
        taken_next        = taken_reg;
        ret_pre_next      = ret_pre_reg;
        rem_next          = rem_reg;
        q_next            = q_reg;
        div_cnt_next      = div_cnt_reg;
        a_next            = a_reg;
        mul_a_next        = mul_a_reg;
        mul_b_next        = mul_b_reg;
        out_data_next     = out_data_reg;

        // Drain the output register
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next     = s_tuser[1:0];
                    nv_next      = s_tdata[31:0];
                    dur_next     = s_tdata[55:32];
                    kind_in_next = s_tdata[57:56];
                    dt_next      = s_tdata[81:58];
                    state_next   = S_PRE;
                end
            end
            S_PRE:
            begin
                // Compute the shown value first when a move with a nonzero duration retargets a running tween
                cur_next   = end_value_reg;
                taken_next = 1'b0;
                if ((req_reg == REQ_MOVE) && (nv_reg != end_value_reg) && (dur_reg != '0)
                    && moving_now)
                begin
                    ret_pre_next = 1'b1;
                    rem_next     = elapsed_time_reg;
                    q_next       = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
                else
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                case (req_reg)
                    REQ_SNAP:
                    begin
                        start_value_next  = nv_reg;
                        end_value_next    = nv_reg;
                        elapsed_time_next = '0;
                        total_time_next   = '0;
                    end
                    REQ_MOVE:
                    begin
                        if (nv_reg != end_value_reg)
                        begin
                            elapsed_time_next = '0;
                            end_value_next    = nv_reg;
                            if (dur_reg == '0)
                            begin
                                start_value_next = nv_reg;
                                total_time_next  = '0;
                            end
                            else
                            begin
                                start_value_next = cur_reg;
                                total_time_next  = dur_reg;
                                curve_kind_next  = kind_in_reg;
                            end
                        end
                    end
                    REQ_ADVANCE:
                    begin
                        if (moving_now)
                        begin
                            taken_next = 1'b1;
                            if (tick_sum > {1'b0, total_time_reg})
                                elapsed_time_next = total_time_reg;
                            else
                                elapsed_time_next = tick_sum[TB-1:0];
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_POST;
            end
            S_POST:
            begin
                // Settled tweens show the end value exactly
                cur_next = end_value_reg;
                if (moving_now)
                begin
                    ret_pre_next = 1'b0;
                    rem_next     = elapsed_time_reg;
                    q_next       = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                // One quotient bit of elapsed * 2^FB / total per cycle
                rem_next     = trial_ge ? TB'(trial - {1'b0, total_time_reg}) : trial[TB-1:0];
                q_next       = {q_reg[FB-2:0], trial_ge};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(FB - 1))
                begin
                    if ((curve_kind_reg == CURVE_EASE_OUT) || (curve_kind_reg == CURVE_IN_OUT))
                    begin
                        state_next = S_LOOKA;
                    end
                    else
                    begin
                        mul_a_next = {span[VB], span};
                        mul_b_next = {2'b00, q_next};
                        state_next = S_SPAN;
                    end
                end
            end
            S_LOOKA:
            begin
                a_next     = tab_rd;
                state_next = S_LOOKB;
            end
            S_LOOKB:
            begin
                mul_a_next = {{(MUL_A_W - SINE_W){1'b0}}, tab_diff};
                mul_b_next = {2'b00, tab_frac};
                state_next = S_INTERP;
            end
            S_INTERP:
            begin
                // Interpolated sine, then square it or scale the span
                if (curve_kind_reg == CURVE_IN_OUT)
                begin
                    mul_a_next = {{(MUL_A_W - SINE_W){1'b0}}, a_reg + rnd_frac};
                    mul_b_next = {1'b0, a_reg + rnd_frac};
                    state_next = S_SQ;
                end
                else
                begin
                    mul_a_next = {span[VB], span};
                    mul_b_next = {1'b0, a_reg + rnd_frac};
                    state_next = S_SPAN;
                end
            end
            S_SQ:
            begin
                mul_a_next = {span[VB], span};
                mul_b_next = {1'b0, rnd_frac};
                state_next = S_SPAN;
            end
            S_SPAN:
            begin
                cur_next   = start_value_reg + mul_shift[VB-1:0];
                state_next = ret_pre_reg ? S_APPLY : S_FIN;
            end
            S_FIN:
            begin
                // Hand the result over once the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    out_data_next = {6'b0, taken_reg, moving_now, end_value_reg, cur_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and tween state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            m_tvalid_reg     <= 1'b0;
            start_value_reg  <= '0;
            end_value_reg    <= '0;
            elapsed_time_reg <= '0;
            total_time_reg   <= '0;
            curve_kind_reg   <= CURVE_LINEAR;
        end
        else
        begin
            state_reg        <= state_next;
            m_tvalid_reg     <= m_tvalid_next;
            start_value_reg  <= start_value_next;
            end_value_reg    <= end_value_next;
            elapsed_time_reg <= elapsed_time_next;
            total_time_reg   <= total_time_next;
            curve_kind_reg   <= curve_kind_next;
        end
    end

    // Payload and datapath registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        nv_reg       <= nv_next;
        dur_reg      <= dur_next;
        kind_in_reg  <= kind_in_next;
        dt_reg       <= dt_next;
        cur_reg      <= cur_next;
        taken_reg    <= taken_next;
        ret_pre_reg  <= ret_pre_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        div_cnt_reg  <= div_cnt_next;
        a_reg        <= a_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        out_data_reg <= out_data_next;
    end

    // Elapsed time never passes the total
    assert property (@(posedge clk) disable iff (!rst_n)
        elapsed_time_reg <= total_time_reg)
        else $error("elapsed time beyond total time");

    // A snap leaves a settled tween
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) && (req_reg == REQ_SNAP)
        |=> (start_value_reg == end_value_reg) && (total_time_reg == '0))
        else $error("snap left a running tween");

    // A settled result shows the target exactly
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && !out_data_reg[64] |-> out_data_reg[31:0] == out_data_reg[63:32])
        else $error("settled result differs from target");

    // The divider never runs past its last quotient bit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> div_cnt_reg <= DIV_CNT_W'(FB - 1))
        else $error("divider step count overrun");

    // A result is only loaded into a free or draining output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) && m_tvalid_reg && !m_tready |=> state_reg == S_FIN)
        else $error("result overwrote a waiting beat");

endmodule

// ----- dv/eased_tween_generator_core_tb.sv -----
// Self-checking testbench for the eased tween generator core: stream driver, monitor, predictor.
module eased_tween_generator_core_tb;

    import etg_pkg::*;

    // Codes without a name in the package
    localparam logic [1:0] REQ_NONE       = 2'd3;
    localparam logic [1:0] CURVE_RESERVED = 2'd3;

    localparam longint UNIT        = longint'(1) << FRACTION_BITS;
    localparam longint HALF_UNIT   = UNIT >> 1;
    localparam int     RANDOM_GOAL = 1500;
    localparam int     CYCLE_LIMIT = 500000;
    localparam int     QUIET_FROM  = 15000;
    localparam int     QUIET_TO    = 25000;
    localparam int     SETTLE_WAIT = 64;

    typedef struct {
        logic [1:0]         req;
        logic signed [31:0] value;
        logic [23:0]        dur;
        logic [1:0]         curve;
        logic [23:0]        tick;
        bit                 drain;
    } tween_req_t;

    typedef struct {
        logic [31:0] value;
        logic [31:0] target;
        logic        moving;
        logic        taken;
    } tween_res_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Predictor state
    longint start_v;
    longint end_v;
    longint elapsed;
    longint total;
    logic [1:0] curve_now;
    longint quarter_sine [0:SINE_TABLE_ENTRIES];

    tween_req_t tween_reqs_pending [$];
    tween_res_t tween_results_due [$];

    int  cycle_count = 0;
    bit  in_taken = 1'b0;
    int  mismatches = 0;
    int  results_checked = 0;
    int  req_seen [0:3] = '{0, 0, 0, 0};
    int  ticks_taken = 0;
    int  moving_results = 0;
    logic signed [31:0] last_target = '0;

    eased_tween_generator_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    function automatic bit idle_now();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
            return 1'b0;
        return $urandom_range(99, 0) < 22;
    endfunction

    function automatic bit tween_active();
        return total != 0 && elapsed < total;
    endfunction

    // Interpolate the quarter-sine table at a Q0.16 phase
    function automatic longint sine_at(longint q);
        longint pos;
        longint idx;
        longint fr;
        longint a;
        longint b;
        pos = q * SINE_TABLE_ENTRIES;
        idx = pos >> FRACTION_BITS;
        fr  = pos & (UNIT - 1);
        if (idx >= SINE_TABLE_ENTRIES)
            return quarter_sine[SINE_TABLE_ENTRIES];
        a = quarter_sine[idx];
        b = quarter_sine[idx + 1];
        if (b < a)
            b = a;
        return a + (((b - a) * fr + HALF_UNIT) >> FRACTION_BITS);
    endfunction

    // Eased value shown for the present tween state
    function automatic logic signed [31:0] shown_value();
        longint p;
        longint e;
        longint s;
        longint prod;
        if (!tween_active())
            return end_v[31:0];
        p = (elapsed << FRACTION_BITS) / total;
        case (curve_now)
            CURVE_EASE_OUT: e = sine_at(p);
            CURVE_IN_OUT:
            begin
                s = sine_at(p);
                e = (s * s + HALF_UNIT) >> FRACTION_BITS;
            end
            default: e = p;
        endcase
        prod = (end_v - start_v) * e + HALF_UNIT;
        return 32'(start_v + (prod >>> FRACTION_BITS));
    endfunction

    // Apply one request to the tween and return what the core should report
    function automatic tween_res_t step_tween(logic [1:0] req, logic signed [31:0] nv_in,
                                              logic [23:0] dur, logic [1:0] curve,
                                              logic [23:0] tick);
        tween_res_t res;
        longint     nv;
        longint     sum_t;
        nv = longint'(nv_in);
        res.taken = 1'b0;
        case (req)
            REQ_SNAP:
            begin
                start_v = nv;
                end_v   = nv;
                elapsed = 0;
                total   = 0;
            end
            REQ_MOVE:
            begin
                if (nv != end_v) begin
                    if (dur == 0) begin
                        start_v = nv;
                        end_v   = nv;
                        elapsed = 0;
                        total   = 0;
                    end else begin
                        start_v   = longint'(shown_value());
                        end_v     = nv;
                        elapsed   = 0;
                        total     = dur;
                        curve_now = curve;
                    end
                end
            end
            REQ_ADVANCE:
            begin
                if (tween_active()) begin
                    sum_t = elapsed + longint'(tick);
                    elapsed = (sum_t > total) ? total : sum_t;
                    res.taken = 1'b1;
                end
            end
            default: ;
        endcase
        res.value  = shown_value();
        res.target = end_v[31:0];
        res.moving = tween_active();
        return res;
    endfunction

    task automatic queue_req(logic [1:0] req, logic [31:0] value, logic [23:0] dur,
                             logic [1:0] curve, logic [23:0] tick, bit drain);
        tween_req_t r;
        r.req   = req;
        r.value = value;
        r.dur   = dur;
        r.curve = curve;
        r.tick  = tick;
        r.drain = drain;
        if (req == REQ_SNAP || req == REQ_MOVE)
            last_target = value;
        tween_reqs_pending.push_back(r);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Build the quarter-sine table in Q1.16 from a Q2.30 Taylor series
    initial
    begin : sine_setup
        logic [63:0] ang;
        logic [63:0] ang2;
        logic [63:0] term;
        longint      acc;
        longint      ent;
        int          i;
        int          k;
        for (i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
            ang  = (PI_Q30 * 64'(i) + 64'(SINE_TABLE_ENTRIES)) / 64'(2 * SINE_TABLE_ENTRIES);
            ang2 = (ang * ang) >> 30;
            term = ang;
            acc  = longint'(ang);
            for (k = 1; k <= 9; k++) begin
                term = ((term * ang2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            ent = (acc + (longint'(1) << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
            if (ent > UNIT)
                ent = UNIT;
            quarter_sine[i] = ent;
        end
        start_v   = 0;
        end_v     = 0;
        elapsed   = 0;
        total     = 0;
        curve_now = CURVE_LINEAR;
    end

    // Drive request beats and the result-side ready at the falling edge
    always @(negedge clk)
    begin : driver
        tween_req_t         nxt;
        logic [IN_DATA_W-1:0] beat;
        if (rst_n && (!s_tvalid || in_taken)) begin
            if (tween_reqs_pending.size() != 0 && !idle_now() &&
                !(tween_reqs_pending[0].drain && tween_results_due.size() != 0)) begin
                nxt  = tween_reqs_pending.pop_front();
                beat = '0;
                beat[31:0]  = nxt.value;
                beat[55:32] = nxt.dur;
                beat[57:56] = nxt.curve;
                beat[81:58] = nxt.tick;
                s_tdata  <= beat;
                s_tuser  <= nxt.req;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= !idle_now();
    end

    // Check result beats and predict each accepted request beat
    always @(posedge clk)
    begin : monitor
        tween_res_t want;
        cycle_count++;
        in_taken = 1'b0;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (tween_results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_tdata);
                end else begin
                    want = tween_results_due.pop_front();
                    results_checked++;
                    check_field("current_value", want.value, m_tdata[31:0]);
                    check_field("target_value", want.target, m_tdata[63:32]);
                    check_field("moving", 32'(want.moving), 32'(m_tdata[64]));
                    check_field("tick_taken", 32'(want.taken), 32'(m_tdata[65]));
                    if (want.moving)
                        moving_results++;
                    if (want.taken)
                        ticks_taken++;
                end
            end
            if (s_tvalid && s_tready) begin
                req_seen[s_tuser]++;
                tween_results_due.push_back(step_tween(s_tuser, s_tdata[31:0], s_tdata[55:32],
                                                       s_tdata[57:56], s_tdata[81:58]));
                in_taken = 1'b1;
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, tween_results_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          counted;
        int          pick;
        int          n;
        int          j;
        logic [31:0] tgt;
        logic [23:0] dur;
        logic [23:0] tick;

        // Directed: extremes, every request and curve, the corner cases
        queue_req(REQ_ADVANCE, 32'h0, 24'h0, CURVE_LINEAR, 24'hFFFFFF, 0);     // idle advance
        queue_req(REQ_SNAP, 32'h7FFFFFFF, 24'hFFFFFF, CURVE_IN_OUT, 24'h0, 0);
        queue_req(REQ_MOVE, 32'h80000000, 24'd1000, CURVE_LINEAR, 24'h0, 0);   // full span
        queue_req(REQ_ADVANCE, 32'h0, 24'h0, CURVE_LINEAR, 24'd1, 0);
        queue_req(REQ_ADVANCE, 32'h0, 24'h0, CURVE_LINEAR, 24'd499, 0);
        queue_req(REQ_MOVE, 32'h80000000, 24'd50, CURVE_EASE_OUT, 24'h0, 0);   // same target
        queue_req(REQ_MOVE, 32'h12345678, 24'd300, CURVE_EASE_OUT, 24'h0, 1);  // retarget, drained
        queue_req(REQ_ADVANCE, 32'h0, 24'h0, CURVE_LINEAR, 24'd100, 0);
        queue_req(REQ_MOVE, 32'hFFFF0000, 24'd777, CURVE_IN_OUT, 24'h0, 0);
        queue_req(REQ_ADVANCE, 32'h0, 24'h0, CURVE_LINEAR, 24'd388, 0);
        queue_req(REQ_MOVE, 32'h00010000, 24'd5000, CURVE_IN_OUT, 24'h0, 0);
        queue_req(REQ_ADVANCE, 32'h0, 24'h0, CURVE_LINEAR, 24'd2500, 0);
        queue_req(REQ_ADVANCE, 32'h0, 24'h0, CURVE_LINEAR, 24'hFFFFFF, 0);     // saturate
        queue_req(REQ_ADVANCE, 32'h0, 24'h0, CURVE_LINEAR, 24'd5, 0);
        queue_req(REQ_MOVE, 32'h00AB0000, 24'd0, CURVE_EASE_OUT, 24'h0, 0);    // zero duration
        queue_req(REQ_MOVE, 32'h7FFFFFFF, 24'hFFFFFF, CURVE_RESERVED, 24'h0, 0);
        queue_req(REQ_ADVANCE, 32'h0, 24'h0, CURVE_LINEAR, 24'hFFFFFE, 0);
        queue_req(REQ_NONE, 32'hA5A5A5A5, 24'h5A5A5A, CURVE_RESERVED, 24'hA5A5A5, 0);
        queue_req(REQ_ADVANCE, 32'h0, 24'h0, CURVE_LINEAR, 24'd1, 0);          // lands on total
        queue_req(REQ_SNAP, 32'h0, 24'hFFFFFF, CURVE_RESERVED, 24'hFFFFFF, 0);
        queue_req(REQ_MOVE, 32'hFFFFFFFF, 24'd1, CURVE_EASE_OUT, 24'h0, 0);
        queue_req(REQ_ADVANCE, 32'h0, 24'h0, CURVE_LINEAR, 24'd0, 0);
        queue_req(REQ_ADVANCE, 32'h0, 24'h0, CURVE_LINEAR, 24'd1, 0);

        // Random: mostly move-then-advance sequences, the rest snaps, same-target moves, lone advances and noise
        counted = 0;
        while (counted < RANDOM_GOAL) begin
            pick = $urandom_range(99, 0);
            if (pick < 70) begin
                n = $urandom_range(8, 1);
                for (j = 0; j <= n; j++) begin
                    if (j == 0 || $urandom_range(9, 0) == 0) begin
                        case ($urandom_range(9, 0))
                            0: tgt = $urandom_range(1, 0) ? 32'h7FFFFFFF : 32'h80000000;
                            1: tgt = 32'($signed($urandom_range(32'h40000, 0)) - 32'sh20000);
                            default: tgt = $urandom();
                        endcase
                        pick = $urandom_range(99, 0);
                        if (pick < 85)
                            dur = 24'($urandom_range(2000, 1));
                        else if (pick < 95)
                            dur = 24'($urandom_range(65535, 1));
                        else
                            dur = 24'($urandom());
                        queue_req(REQ_MOVE, tgt, dur, 2'($urandom_range(3, 0)),
                                  24'($urandom()), counted == 0 || counted == 750);
                    end else begin
                        if ($urandom_range(99, 0) < 15)
                            tick = 24'($urandom());
                        else
                            tick = 24'($urandom_range(int'(dur) / 4 + 1, 0));
                        queue_req(REQ_ADVANCE, $urandom(), 24'($urandom()),
                                  2'($urandom_range(3, 0)), tick, 0);
                    end
                    counted++;
                end
            end else if (pick < 80) begin
                queue_req(REQ_SNAP, $urandom(), 24'($urandom()), 2'($urandom_range(3, 0)),
                          24'($urandom()), 0);
                counted++;
            end else if (pick < 88) begin
                queue_req(REQ_MOVE, last_target, 24'($urandom()), 2'($urandom_range(3, 0)),
                          24'($urandom()), 0);
            end else if (pick < 93) begin
                queue_req(REQ_ADVANCE, $urandom(), 24'($urandom()), 2'($urandom_range(3, 0)),
                          24'($urandom()), 0);
            end else begin
                queue_req(2'($urandom_range(3, 0)), $urandom(), 24'($urandom()),
                          2'($urandom_range(3, 0)), 24'($urandom()), 0);
            end
        end

        // Hold reset, then release it away from the active edge
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every request to go out and every result to come back
        while (tween_reqs_pending.size() != 0 || s_tvalid || tween_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);

        $display("Checked %0d results: %0d snaps, %0d moves, %0d advances, %0d unknown requests",
                 results_checked, req_seen[0], req_seen[1], req_seen[2], req_seen[3]);
        $display("Advances that took time: %0d; results still moving: %0d; mismatches: %0d",
                 ticks_taken, moving_results, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/etg_pkg.sv
rtl/eased_tween_generator_core.sv
dv/eased_tween_generator_core_tb.sv
